FILE: rtl/first_fit_block_allocator_core_macros.svh
// Assertion macros used by the allocator checker.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication.
`define FFBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FFBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ffba_pkg.sv
package ffba_pkg;

    localparam int ENTRY_W     = 14;
    localparam int GAP_W       = ENTRY_W + 1;
    localparam int REQ_BYTES_W = 20;
    localparam int REL_ADDR_W  = 19;
    localparam int ADDR_W      = 20;
    localparam int CFG_IDX_W   = 2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_FLOOR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REVERB = 2'd2;

    typedef enum logic [1:0] {
        ST_ALLOC_OK   = 2'd0,
        ST_ALLOC_FAIL = 2'd1,
        ST_FREED      = 2'd2,
        ST_FREE_MISS  = 2'd3
    } t_status;

    typedef struct packed {
        logic                   cmd;
        logic [REQ_BYTES_W-1:0] request_bytes;
        logic [REL_ADDR_W-1:0]  release_address;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] granted_address;
    } t_rsp;

    typedef struct packed {
        logic [ENTRY_W-1:0] start;
        logic [ENTRY_W-1:0] length;
    } t_entry;

endpackage

FILE: rtl/first_fit_block_allocator_core.sv
// First-fit block allocator over a sorted table of {start, length} entries.
// Allocate: dispatch, then per entry walked a table read and a gap test, per entry moved
// up a read and a write, then insert. Free: dispatch, walk, move later entries down.
// A full table or an empty free answers at dispatch. Each step waits on the one table read port.
// A new item is taken only while idle: busy drops with the one-cycle result beat; no stall.
// Sync reset clears state, count, strobe and config registers; payload registers and table contents are not cleared.
module first_fit_block_allocator_core #(
    parameter int TABLE_DEPTH = 128,
    parameter int BLOCK_LOG2  = 6,
    parameter int AREA_BLOCKS = 8192
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  ffba_pkg::t_req               i_req,
    output logic                         o_strobe,
    output ffba_pkg::t_rsp               o_rsp,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [ffba_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ffba_pkg::ENTRY_W-1:0] i_cfg_data
);
    import ffba_pkg::*;

    // table index and count widths
    localparam int IW       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW       = IW + 1;
    // need in blocks: 20-bit byte count plus rounding, shifted down
    localparam int NW       = REQ_BYTES_W + 1 - BLOCK_LOG2;
    // release block width and match compare width
    localparam int RBW      = REL_ADDR_W - BLOCK_LOG2;
    localparam int MW       = (RBW > ENTRY_W) ? RBW : ENTRY_W;
    localparam int BLK_MASK = (1 << BLOCK_LOG2) - 1;
    localparam logic [ENTRY_W-1:0] AREA_RST = ENTRY_W'(AREA_BLOCKS);

    // One-hot sequencer.
    //   CHK  : dispatch, table word 0 is being read
    //   RD   : read cycle for the walk pointer
    //   EVAL : gap test (alloc) or start match (free) on read data
    //   TAIL : gap after the last entry up to top_block
    //   MRD/MWR : move one entry (up for alloc, down for free)
    //   INS  : write the new entry
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_CHK  = 8'b0000_0010,
        S_RD   = 8'b0000_0100,
        S_EVAL = 8'b0000_1000,
        S_TAIL = 8'b0001_0000,
        S_MRD  = 8'b0010_0000,
        S_MWR  = 8'b0100_0000,
        S_INS  = 8'b1000_0000
    } t_state;

    t_state             r_state, n_state;
    logic               r_cmd, n_cmd;
    logic [IW-1:0]      r_ptr, n_ptr;
    logic [IW-1:0]      r_ins, n_ins;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [GAP_W-1:0]   r_blk, n_blk;
    logic [NW-1:0]      r_need, n_need;
    logic [RBW-1:0]     r_rel, n_rel;
    t_entry             r_new, n_new;
    logic [ADDR_W-1:0]  r_grant, n_grant;
    logic [ENTRY_W-1:0] r_floor, r_top, r_reverb;
    logic               r_strobe, n_strobe;
    t_rsp               r_rsp, n_rsp;

    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    t_entry             mem_wdata;
    t_entry             mem_rdata;

    logic [GAP_W-1:0]   gap_end;
    logic [GAP_W-1:0]   gap_blk;
    logic               gap_fit;
    logic               last_entry;
    logic               start_match;
    logic [31:0]        grant_wide;

    ffba_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_ptr),
        .o_rdata (mem_rdata)
    );

    // shared clamp/compare unit; tail gap ends at top_block
    assign gap_end = (r_state == S_TAIL) ? {1'b0, r_top} : {1'b0, mem_rdata.start};

    ffba_gap #(
        .NEED_W (NW)
    ) u_gap (
        .i_blk    (r_blk),
        .i_end    (gap_end),
        .i_floor  (r_floor),
        .i_top    (r_top),
        .i_reverb (r_reverb),
        .i_need   (r_need),
        .o_blk    (gap_blk),
        .o_fit    (gap_fit)
    );

    assign last_entry  = ((CW'(r_ptr) + CW'(1)) == r_cnt);
    assign start_match = (MW'(r_rel) == MW'(mem_rdata.start));
    assign grant_wide  = 32'(gap_blk) << BLOCK_LOG2;

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_ptr     = r_ptr;
        n_ins     = r_ins;
        n_cnt     = r_cnt;
        n_blk     = r_blk;
        n_need    = r_need;
        n_rel     = r_rel;
        n_new     = r_new;
        n_grant   = r_grant;
        n_strobe  = 1'b0;
        n_rsp     = r_rsp;
        mem_we    = 1'b0;
        mem_waddr = r_ptr;
        mem_wdata = mem_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd   = i_req.cmd;
                    n_need  = NW'(({1'b0, i_req.request_bytes} + (REQ_BYTES_W + 1)'(BLK_MASK))
                                  >> BLOCK_LOG2);
                    n_rel   = RBW'(i_req.release_address >> BLOCK_LOG2);
                    n_ptr   = '0;
                    n_blk   = {1'b0, r_floor};
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_cmd == CMD_ALLOC) begin
                    if (r_cnt >= CW'(TABLE_DEPTH)) begin
                        n_strobe = 1'b1;
                        n_rsp    = '{status: ST_ALLOC_FAIL, granted_address: '0};
                        n_state  = S_IDLE;
                    end else if (r_cnt == '0) begin
                        n_state = S_TAIL;
                    end else begin
                        n_state = S_EVAL;
                    end
                end else if (r_cnt == '0) begin
                    n_strobe = 1'b1;
                    n_rsp    = '{status: ST_FREE_MISS, granted_address: '0};
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_RD: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (r_cmd == CMD_ALLOC) begin
                    if (gap_fit) begin
                        // insert before this entry: move r_cnt-1 .. r_ptr up
                        n_ins   = r_ptr;
                        n_new   = '{start: gap_blk[ENTRY_W-1:0], length: ENTRY_W'(r_need)};
                        n_grant = grant_wide[ADDR_W-1:0];
                        n_ptr   = IW'(r_cnt - CW'(1));
                        n_state = S_MRD;
                    end else begin
                        // next gap begins at end of this entry, unclamped
                        n_blk = {1'b0, mem_rdata.start} + {1'b0, mem_rdata.length};
                        if (last_entry) begin
                            n_state = S_TAIL;
                        end else begin
                            n_ptr   = r_ptr + IW'(1);
                            n_state = S_RD;
                        end
                    end
                end else if (start_match) begin
                    if (last_entry) begin
                        n_cnt    = r_cnt - CW'(1);
                        n_strobe = 1'b1;
                        n_rsp    = '{status: ST_FREED, granted_address: '0};
                        n_state  = S_IDLE;
                    end else begin
                        n_ptr   = r_ptr + IW'(1);
                        n_state = S_MRD;
                    end
                end else if (last_entry) begin
                    n_strobe = 1'b1;
                    n_rsp    = '{status: ST_FREE_MISS, granted_address: '0};
                    n_state  = S_IDLE;
                end else begin
                    n_ptr   = r_ptr + IW'(1);
                    n_state = S_RD;
                end
            end
            S_TAIL: begin
                if (gap_fit) begin
                    n_ins   = IW'(r_cnt);
                    n_new   = '{start: gap_blk[ENTRY_W-1:0], length: ENTRY_W'(r_need)};
                    n_grant = grant_wide[ADDR_W-1:0];
                    n_state = S_INS;
                end else begin
                    n_strobe = 1'b1;
                    n_rsp    = '{status: ST_ALLOC_FAIL, granted_address: '0};
                    n_state  = S_IDLE;
                end
            end
            S_MRD: begin
                n_state = S_MWR;
            end
            S_MWR: begin
                mem_we = 1'b1;
                if (r_cmd == CMD_ALLOC) begin
                    mem_waddr = r_ptr + IW'(1);
                    if (r_ptr == r_ins) begin
                        n_state = S_INS;
                    end else begin
                        n_ptr   = r_ptr - IW'(1);
                        n_state = S_MRD;
                    end
                end else begin
                    mem_waddr = r_ptr - IW'(1);
                    if (last_entry) begin
                        n_cnt    = r_cnt - CW'(1);
                        n_strobe = 1'b1;
                        n_rsp    = '{status: ST_FREED, granted_address: '0};
                        n_state  = S_IDLE;
                    end else begin
                        n_ptr   = r_ptr + IW'(1);
                        n_state = S_MRD;
                    end
                end
            end
            S_INS: begin
                mem_we    = 1'b1;
                mem_waddr = r_ins;
                mem_wdata = r_new;
                n_cnt     = r_cnt + CW'(1);
                n_strobe  = 1'b1;
                n_rsp     = '{status: ST_ALLOC_OK, granted_address: r_grant};
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_strobe <= n_strobe;
        end
    end

    // config registers; written only while idle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor  <= '0;
            r_top    <= AREA_RST;
            r_reverb <= AREA_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_FLOOR:  r_floor  <= i_cfg_data;
                REG_TOP:    r_top    <= i_cfg_data;
                REG_REVERB: r_reverb <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // payload / datapath
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_ptr   <= n_ptr;
        r_ins   <= n_ins;
        r_blk   <= n_blk;
        r_need  <= n_need;
        r_rel   <= n_rel;
        r_new   <= n_new;
        r_grant <= n_grant;
        r_rsp   <= n_rsp;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_rsp       = r_rsp;
    // no config beat while an item runs or is being taken
    assign o_cfg_ready = (r_state == S_IDLE) && !start;

endmodule

FILE: rtl/ffba_gap.sv
// Gap clamp and fit test: end is min(end, top, reverb), start is max(blk, floor).
module ffba_gap #(
    parameter int NEED_W = 15
) (
    input  logic [ffba_pkg::GAP_W-1:0]   i_blk,
    input  logic [ffba_pkg::GAP_W-1:0]   i_end,
    input  logic [ffba_pkg::ENTRY_W-1:0] i_floor,
    input  logic [ffba_pkg::ENTRY_W-1:0] i_top,
    input  logic [ffba_pkg::ENTRY_W-1:0] i_reverb,
    input  logic [NEED_W-1:0]            i_need,
    output logic [ffba_pkg::GAP_W-1:0]   o_blk,
    output logic                         o_fit
);
    import ffba_pkg::*;

    localparam int CW = (NEED_W > GAP_W) ? NEED_W : GAP_W;

    logic [GAP_W-1:0] floor_x;
    logic [GAP_W-1:0] top_x;
    logic [GAP_W-1:0] rv_x;
    logic [GAP_W-1:0] end_a;
    logic [GAP_W-1:0] end_b;
    logic [GAP_W-1:0] room;

    assign floor_x = {1'b0, i_floor};
    assign top_x   = {1'b0, i_top};
    assign rv_x    = {1'b0, i_reverb};

    assign o_blk = (i_blk < floor_x) ? floor_x : i_blk;
    assign end_a = (i_end > top_x) ? top_x : i_end;
    assign end_b = (end_a > rv_x) ? rv_x : end_a;
    assign room  = end_b - o_blk;
    // negative room never fits
    assign o_fit = (end_b >= o_blk) && (CW'(room) >= CW'(i_need));

endmodule

FILE: rtl/ffba_table.sv
// Entry table: one write port, one read port, registered read data.
module ffba_table #(
    parameter int DEPTH = 128
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  ffba_pkg::t_entry           i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output ffba_pkg::t_entry           o_rdata
);
    import ffba_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/ffba_checker.sv
`include "first_fit_block_allocator_core_macros.svh"

module ffba_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_strobe,
    input ffba_pkg::t_rsp o_rsp
);
    import ffba_pkg::*;

    `FFBA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accepted beat did not raise busy")
    `FFBA_ASSERT_NOW(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy, "result beat while busy")
    `FFBA_ASSERT_NOW(a_fell_strobe, i_clk, i_rst_n, $fell(busy), o_strobe, "busy dropped without result beat")
    `FFBA_ASSERT_NEXT(a_strobe_pulse, i_clk, i_rst_n, o_strobe, !o_strobe, "result beat longer than one cycle")
    `FFBA_ASSERT_NOW(a_addr_zero, i_clk, i_rst_n, o_strobe && (o_rsp.status != ST_ALLOC_OK), o_rsp.granted_address == '0, "address set on non-grant beat")

endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_rsp    (o_rsp)
);
